// File: hw/rtl/maxsat_clause_evaluator_macros.svh
// Assertion macros for the clause evaluator checker.
`ifndef MAXSAT_CLAUSE_EVALUATOR_MACROS_SVH
`define MAXSAT_CLAUSE_EVALUATOR_MACROS_SVH

// Clocked assertion, disabled while reset is high.
`define MAXCE_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define MAXCE_ASSERT_NR(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hw/rtl/maxce_pkg.sv
// Types and constants of the MaxSAT clause evaluator.
`default_nettype none

package maxce_pkg;

   localparam int DEF_MAX_VARS     = 1024;
   localparam int DEF_MAX_CLAUSES  = 4096;
   localparam int DEF_MAX_LITERALS = 8192;

   localparam int VAR_IDX_W = 10;
   localparam int SAT_CNT_W = 13;
   localparam int EVAL_CNT_W = 32;
   // wide enough for any variable or clause count in the parameter range
   localparam int EXT_W = 17;

   typedef enum logic [1:0] {
      OP_CLEAR  = 2'd0,
      OP_APPEND = 2'd1,
      OP_SET    = 2'd2,
      OP_EVAL   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EVAL,
      ST_DONE
   } state_type;

   typedef struct packed {
      op_type                 opcode;
      logic [VAR_IDX_W-1:0]   var_index;
      logic                   negated;
      logic                   clause_end;
      logic                   var_value;
   } req_type;

   typedef struct packed {
      logic [SAT_CNT_W-1:0]   satisfied_count;
      logic [EVAL_CNT_W-1:0]  eval_count;
      logic                   store_overflow;
   } rsp_type;

   typedef struct packed {
      logic                   clause_end;
      logic                   negated;
      logic [VAR_IDX_W-1:0]   var_index;
   } lit_type;

   localparam int LIT_W = $bits(lit_type);

endpackage

`default_nettype wire

// File: hw/rtl/maxce_ram.sv
// Generic single write port, single read port RAM with registered read.
`default_nettype none

module maxce_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: hw/rtl/maxsat_clause_evaluator.sv
// MaxSAT clause evaluator top level: clause store, assignment memory, evaluation walk.
//
//   channel  dir  handshake           payload
//   req      in   req_valid/req_stall   maxce_pkg::req_type
//   rsp      out  rsp_valid/rsp_stall   maxce_pkg::rsp_type
//
// Clear, append and set items do not stall the input.
// Evaluate walks the literal memory one literal per cycle, each literal then
// reading the assignment memory; the clause sum then passes through the DONE
// state into the result register, with req_stall high meanwhile.
// After reset a sweep zeroes all MAX_VARS assignment memory entries; req_stall
// stays high during it. A waiting result holds while rsp_stall is high; new items
// are still taken, and a later evaluate waits in its last step for the slot.
`default_nettype none

module maxsat_clause_evaluator #(
   parameter int MAX_VARS     = maxce_pkg::DEF_MAX_VARS,
   parameter int MAX_CLAUSES  = maxce_pkg::DEF_MAX_CLAUSES,
   parameter int MAX_LITERALS = maxce_pkg::DEF_MAX_LITERALS
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  maxce_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output maxce_pkg::rsp_type rsp_data
);

   localparam int VAR_AW = $clog2(MAX_VARS);
   localparam int LIT_AW = (MAX_LITERALS > 1) ? $clog2(MAX_LITERALS) : 1;
   localparam int LIT_CW = $clog2(MAX_LITERALS + 1);
   localparam int CLS_CW = $clog2(MAX_CLAUSES + 1);
   localparam int EXT_W  = maxce_pkg::EXT_W;
   localparam int EVW    = maxce_pkg::EVAL_CNT_W;

   maxce_pkg::state_type state_ff, state_in;

   logic [LIT_CW-1:0] lit_total_ff, lit_total_in;
   logic [CLS_CW-1:0] cls_total_ff, cls_total_in;
   logic              ovf_ff, ovf_in;
   logic [EVW-1:0]    evcnt_ff, evcnt_in;
   logic [VAR_AW-1:0] clr_idx_ff, clr_idx_in;
   logic [LIT_CW-1:0] idx_ff, idx_in;
   logic              s1_ff, s1_in;
   logic              s2_ff, s2_in;
   logic              s2_neg_ff, s2_end_ff, s2_inr_ff;
   logic              sat_ff, sat_in;
   logic [CLS_CW-1:0] sum_ff, sum_in;
   logic              rsp_valid_ff, rsp_valid_in;
   maxce_pkg::rsp_type rsp_data_ff;

   logic accept, full, walk_en, clr_en, load, issue, walk_done;
   logic is_clear, is_append, is_set, is_eval;
   logic set_inr, lit_inr, lit_true, any_true;
   logic [EXT_W-1:0]  set_ext, lit_ext, sum_ext;
   maxce_pkg::lit_type lit_wr, lit_q;
   logic [maxce_pkg::LIT_W-1:0] lit_q_raw;
   logic [0:0] var_wr_data, var_q;
   logic [VAR_AW-1:0] var_wr_addr;
   logic var_wr_en;

   assign accept = req_valid && !req_stall;

   always_comb begin
      is_clear  = 1'b0;
      is_append = 1'b0;
      is_set    = 1'b0;
      is_eval   = 1'b0;
      case (req_data.opcode)
         maxce_pkg::OP_CLEAR:  is_clear  = accept;
         maxce_pkg::OP_APPEND: is_append = accept;
         maxce_pkg::OP_SET:    is_set    = accept;
         maxce_pkg::OP_EVAL:   is_eval   = accept;
         default:              is_clear  = 1'b0;
      endcase
   end

   assign full = (lit_total_ff == LIT_CW'(MAX_LITERALS)) ||
                 (cls_total_ff == CLS_CW'(MAX_CLAUSES));

   assign walk_done = (idx_ff == lit_total_ff) && !s1_ff && !s2_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         maxce_pkg::ST_CLEAR: begin
            if (clr_idx_ff == VAR_AW'(MAX_VARS - 1)) state_in = maxce_pkg::ST_IDLE;
         end
         maxce_pkg::ST_IDLE: begin
            if (is_eval) state_in = maxce_pkg::ST_EVAL;
         end
         maxce_pkg::ST_EVAL: begin
            if (walk_done) state_in = maxce_pkg::ST_DONE;
         end
         maxce_pkg::ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) state_in = maxce_pkg::ST_IDLE;
         end
         default: state_in = maxce_pkg::ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_stall = 1'b1;
      walk_en   = 1'b0;
      clr_en    = 1'b0;
      load      = 1'b0;
      case (state_ff)
         maxce_pkg::ST_CLEAR: clr_en    = 1'b1;
         maxce_pkg::ST_IDLE:  req_stall = 1'b0;
         maxce_pkg::ST_EVAL:  walk_en   = 1'b1;
         maxce_pkg::ST_DONE:  load      = !rsp_valid_ff || !rsp_stall;
         default:             req_stall = 1'b1;
      endcase
   end

   assign issue = walk_en && (idx_ff != lit_total_ff);

   // literal memory
   assign lit_wr = '{clause_end: req_data.clause_end,
                     negated:    req_data.negated,
                     var_index:  req_data.var_index};

   maxce_ram #(
      .WIDTH (maxce_pkg::LIT_W),
      .DEPTH (MAX_LITERALS)
   ) u_lit_ram (
      .clock   (clock),
      .wr_en   (is_append && !full),
      .wr_addr (lit_total_ff[LIT_AW-1:0]),
      .wr_data (lit_wr),
      .rd_en   (issue),
      .rd_addr (idx_ff[LIT_AW-1:0]),
      .rd_data (lit_q_raw)
   );

   assign lit_q = maxce_pkg::lit_type'(lit_q_raw);

   // assignment memory
   assign set_ext = EXT_W'(req_data.var_index);
   assign set_inr = set_ext < EXT_W'(MAX_VARS);
   assign lit_ext = EXT_W'(lit_q.var_index);
   assign lit_inr = lit_ext < EXT_W'(MAX_VARS);

   assign var_wr_en   = clr_en || (is_set && set_inr);
   assign var_wr_addr = clr_en ? clr_idx_ff : set_ext[VAR_AW-1:0];
   assign var_wr_data = clr_en ? 1'b0 : req_data.var_value;

   maxce_ram #(
      .WIDTH (1),
      .DEPTH (MAX_VARS)
   ) u_var_ram (
      .clock   (clock),
      .wr_en   (var_wr_en),
      .wr_addr (var_wr_addr),
      .wr_data (var_wr_data),
      .rd_en   (s1_ff),
      .rd_addr (lit_ext[VAR_AW-1:0]),
      .rd_data (var_q)
   );

   // store bookkeeping
   always_comb begin
      lit_total_in = lit_total_ff;
      cls_total_in = cls_total_ff;
      ovf_in       = ovf_ff;
      evcnt_in     = evcnt_ff;
      if (is_clear) begin
         lit_total_in = '0;
         cls_total_in = '0;
      end
      if (is_append) begin
         if (full) begin
            ovf_in = 1'b1;
         end else begin
            lit_total_in = lit_total_ff + LIT_CW'(1);
            cls_total_in = cls_total_ff + CLS_CW'(req_data.clause_end);
         end
      end
      if (is_eval && (evcnt_ff != {EVW{1'b1}})) begin
         evcnt_in = evcnt_ff + EVW'(1);
      end
   end

   assign clr_idx_in = clr_en ? clr_idx_ff + VAR_AW'(1) : clr_idx_ff;

   // evaluation walk
   assign lit_true = (s2_inr_ff & var_q[0]) != s2_neg_ff;
   assign any_true = sat_ff | lit_true;

   always_comb begin
      idx_in = idx_ff;
      sat_in = sat_ff;
      sum_in = sum_ff;
      if (is_eval) begin
         idx_in = '0;
         sat_in = 1'b0;
         sum_in = '0;
      end else begin
         if (issue) idx_in = idx_ff + LIT_CW'(1);
         if (s2_ff) begin
            if (s2_end_ff) begin
               sum_in = sum_ff + CLS_CW'(any_true);
               sat_in = 1'b0;
            end else begin
               sat_in = any_true;
            end
         end
      end
   end

   assign s1_in = issue;
   assign s2_in = s1_ff;

   // result register
   assign rsp_valid_in = load || (rsp_valid_ff && rsp_stall);
   assign sum_ext      = EXT_W'(sum_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= maxce_pkg::ST_CLEAR;
         lit_total_ff <= '0;
         cls_total_ff <= '0;
         ovf_ff       <= 1'b0;
         evcnt_ff     <= '0;
         clr_idx_ff   <= '0;
         idx_ff       <= '0;
         s1_ff        <= 1'b0;
         s2_ff        <= 1'b0;
         sat_ff       <= 1'b0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         lit_total_ff <= lit_total_in;
         cls_total_ff <= cls_total_in;
         ovf_ff       <= ovf_in;
         evcnt_ff     <= evcnt_in;
         clr_idx_ff   <= clr_idx_in;
         idx_ff       <= idx_in;
         s1_ff        <= s1_in;
         s2_ff        <= s2_in;
         sat_ff       <= sat_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ff) begin
         s2_neg_ff <= lit_q.negated;
         s2_end_ff <= lit_q.clause_end;
         s2_inr_ff <= lit_inr;
      end
      if (load) begin
         rsp_data_ff.satisfied_count <= sum_ext[maxce_pkg::SAT_CNT_W-1:0];
         rsp_data_ff.eval_count      <= evcnt_ff;
         rsp_data_ff.store_overflow  <= ovf_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

// File: hw/rtl/maxce_check.sv
// Port-level assertions for the clause evaluator, bound to the top level.
`default_nettype none
`include "maxsat_clause_evaluator_macros.svh"

module maxce_check (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input maxce_pkg::req_type req_data,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input maxce_pkg::rsp_type rsp_data
);

   // hold a stalled result
   `MAXCE_ASSERT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data), "stalled result changed")

   // an evaluate item blocks the input while the walk runs
   `MAXCE_ASSERT(a_eval_stalls, clock, reset, req_valid && !req_stall && req_data.opcode == maxce_pkg::OP_EVAL |=> req_stall, "input open during evaluation")

   // every result follows at least one counted evaluation
   `MAXCE_ASSERT(a_count_nonzero, clock, reset, rsp_valid |-> rsp_data.eval_count != 32'd0, "result with zero evaluation count")

   // assignment sweep blocks input right after reset
   `MAXCE_ASSERT_NR(a_sweep_stall, clock, reset |=> req_stall, "input open after reset")

endmodule

bind maxsat_clause_evaluator maxce_check u_check (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

`default_nettype wire
